/* rtl/pfe_pkg.sv */
// Shared types and constants for the particle force / Euler step block.
package pfe_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MASS        = 3'd0,
        REG_GRAVITY     = 3'd1,
        REG_DRAG        = 3'd2,
        REG_WIND        = 3'd3,
        REG_START_X     = 3'd4,
        REG_START_Y     = 3'd5,
        REG_START_VEL_X = 3'd6,
        REG_START_VEL_Y = 3'd7
    } cfg_reg_t;

    localparam logic signed [31:0] GRAVITY_RESET = -32'sd642908;
    localparam logic [30:0]        MAX31         = 31'h7FFF_FFFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_MUL_KS,
        OP_KS,
        OP_MUL_DX,
        OP_FX,
        OP_MUL_DY,
        OP_FY,
        OP_IMPACT,
        OP_DIV_START,
        OP_DIV_END,
        OP_MUL_AX,
        OP_VX,
        OP_MUL_AY,
        OP_VY,
        OP_MUL_PX,
        OP_PX,
        OP_MUL_PY,
        OP_PY,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_SUM,
        OP_SQRT_START,
        OP_SQRT_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic restart;
        logic collision;
        logic div_done;
        logic sqrt_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_MUL_KS,
        S_KS,
        S_MUL_DX,
        S_FX,
        S_MUL_DY,
        S_FY,
        S_IMPACT,
        S_DIV_START,
        S_DIV_RUN,
        S_DIV_END,
        S_MUL_AX,
        S_VX,
        S_MUL_AY,
        S_VY,
        S_MUL_PX,
        S_PX,
        S_MUL_PY,
        S_PY,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_SUM,
        S_SQRT_START,
        S_SQRT_RUN,
        S_SQRT_END,
        S_OUT
    } ctrl_state_t;

endpackage

/* rtl/particle_force_euler_step.sv */
// Top level: 2D point-mass force and explicit Euler step, Q fixed point.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | one step request: restart / collision flags, dt, impact
//  m_      | out       | new position, velocity, speed and clamp flag
//  cfg_    | in        | write-only register port, index 0..7
//
// Flow: one request at a time. An ordinary step runs drag, the serial divide by
// mass (32 + FRAC_BITS steps, both axes in parallel), the Euler update and the
// 32-step square root; an impact step skips the drag terms, and a restart loads
// the start registers and goes straight to the speed computation.
// Reset: synchronous, active low; clears state, loads register defaults.
// Stalls: the result holds on m_ until taken; s_tready is low meanwhile.
module particle_force_euler_step #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // time_step[16:0], impact_force_x[48:17], impact_force_y[80:49]
    input  logic [87:0]                    s_tdata,
    // restart[0], in_collision[1]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], speed_out[158:128]
    output logic [159:0]                   m_tdata,
    // saturated[0]
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [pfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pfe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       sat;

    // controller owns the handshakes; datapath only sees commands
    pfe_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd)
    );

    pfe_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_flags(s_tuser), .in_data(s_tdata[80:0]),
        .out_data(m_tdata), .out_sat(sat)
    );

    assign m_tuser = sat;
endmodule

/* rtl/pfe_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module pfe_div #(
    parameter int unsigned NUM_W = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [30:0]      denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [30:0]      rem_reg, rem_next;
    logic [31:0]      rem_sh;
    logic [31:0]      diff;

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, denom};

    always_comb begin
        count_next = count_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        if (start) begin
            count_next = CNT_W'(NUM_W);
            num_next   = numer;
            rem_next   = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            if (rem_sh >= {1'b0, denom}) begin
                rem_next = diff[30:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[30:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = (count_reg == '0);
    assign quot = num_reg;
endmodule

/* rtl/pfe_sqrt.sv */
// Serial integer square root of a 64-bit value, one root bit per cycle.
module pfe_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [5:0]  count_reg, count_next;
    logic [63:0] rad_reg, rad_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    assign rem_sh = {rem_reg[32:0], rad_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb begin
        count_next = count_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        if (start) begin
            count_next = 6'd32;
            rad_next   = radicand;
            rem_next   = '0;
            root_next  = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            rad_next   = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (count_reg == '0);
    assign root = root_reg;
endmodule

/* rtl/pfe_datapath.sv */
// Datapath: config and state registers, shared multiplier, divider and root units.
module pfe_datapath #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pfe_pkg::dp_cmd_t              cmd,
    output pfe_pkg::dp_status_t           status,
    input  logic                          cfg_wr_en,
    input  logic [pfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]                    in_flags,
    input  logic [80:0]                   in_data,
    output logic [159:0]                  out_data,
    output logic                          out_sat
);
    import pfe_pkg::*;

    localparam int unsigned NUM_W = 32 + FRAC_BITS;

    // configuration
    logic [30:0]        mass_reg;
    logic signed [31:0] gravity_reg, wind_reg;
    logic [30:0]        drag_reg;
    logic signed [31:0] start_x_reg, start_y_reg, start_vx_reg, start_vy_reg;

    // state and work registers
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [30:0]        speed_reg;
    logic               sat_reg;
    logic               restart_reg, coll_reg;
    logic [16:0]        dt_reg;
    logic signed [31:0] imp_x_reg, imp_y_reg;
    logic [30:0]        ks_reg;
    logic signed [31:0] fx_reg, fy_reg, ax_reg, ay_reg;
    logic signed [65:0] prod_reg;
    logic [63:0]        acc_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_sh;
    logic [30:0]        denom;
    logic               div_x_done, div_y_done, sqrt_done;
    logic [NUM_W-1:0]   quot_x, quot_y, numer_x, numer_y;
    logic [31:0]        root;
    logic [63:0]        sq_sum;

    function automatic logic [32:0] clamp32(input logic signed [67:0] x);
        if (x > 68'sd2147483647) begin
            clamp32 = {1'b1, 32'h7FFF_FFFF};
        end else if (x < -68'sd2147483648) begin
            clamp32 = {1'b1, 32'h8000_0000};
        end else begin
            clamp32 = {1'b0, x[31:0]};
        end
    endfunction

    function automatic logic [NUM_W-1:0] mag_shift(input logic signed [31:0] f);
        logic [31:0] m;
        m = f[31] ? 32'(-f) : 32'(f);
        mag_shift = {m, FRAC_BITS'(0)};
    endfunction

    function automatic logic signed [67:0] signed_quot(input logic neg,
                                                       input logic [NUM_W-1:0] q);
        logic signed [67:0] v;
        v = $signed(68'(q));
        signed_quot = neg ? -v : v;
    endfunction

    logic [32:0] c_fx, c_fy, c_ax, c_ay, c_vx, c_vy, c_px, c_py;

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign c_fx = clamp32(68'(wind_reg) - 68'(prod_sh));
    assign c_fy = clamp32(68'(gravity_reg) - 68'(prod_sh));
    assign c_ax = clamp32(signed_quot(fx_reg[31], quot_x));
    assign c_ay = clamp32(signed_quot(fy_reg[31], quot_y));
    assign c_vx = clamp32(68'(vel_x_reg) + 68'(prod_sh));
    assign c_vy = clamp32(68'(vel_y_reg) + 68'(prod_sh));
    assign c_px = clamp32(68'(pos_x_reg) + 68'(prod_sh));
    assign c_py = clamp32(68'(pos_y_reg) + 68'(prod_sh));

    assign denom   = (mass_reg == '0) ? 31'd1 : mass_reg;
    assign numer_x = mag_shift(fx_reg);
    assign numer_y = mag_shift(fy_reg);
    assign sq_sum  = acc_reg + 64'(prod_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_KS: begin
                mul_a = $signed({2'b00, drag_reg});
                mul_b = $signed({2'b00, speed_reg});
            end
            OP_MUL_DX: begin
                mul_a = $signed({2'b00, ks_reg});
                mul_b = 33'(vel_x_reg);
            end
            OP_MUL_DY: begin
                mul_a = $signed({2'b00, ks_reg});
                mul_b = 33'(vel_y_reg);
            end
            OP_MUL_AX: begin
                mul_a = 33'(ax_reg);
                mul_b = $signed({16'd0, dt_reg});
            end
            OP_MUL_AY: begin
                mul_a = 33'(ay_reg);
                mul_b = $signed({16'd0, dt_reg});
            end
            OP_MUL_PX: begin
                mul_a = 33'(vel_x_reg);
                mul_b = $signed({16'd0, dt_reg});
            end
            OP_MUL_PY: begin
                mul_a = 33'(vel_y_reg);
                mul_b = $signed({16'd0, dt_reg});
            end
            OP_SQ_X: begin
                mul_a = 33'(vel_x_reg);
                mul_b = 33'(vel_x_reg);
            end
            OP_SQ_Y: begin
                mul_a = 33'(vel_y_reg);
                mul_b = 33'(vel_y_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg     <= 31'(1 << FRAC_BITS);
            gravity_reg  <= GRAVITY_RESET;
            drag_reg     <= '0;
            wind_reg     <= '0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            start_vx_reg <= '0;
            start_vy_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_MASS:        mass_reg     <= cfg_wdata[30:0];
                REG_GRAVITY:     gravity_reg  <= cfg_wdata;
                REG_DRAG:        drag_reg     <= cfg_wdata[30:0];
                REG_WIND:        wind_reg     <= cfg_wdata;
                REG_START_X:     start_x_reg  <= cfg_wdata;
                REG_START_Y:     start_y_reg  <= cfg_wdata;
                REG_START_VEL_X: start_vx_reg <= cfg_wdata;
                REG_START_VEL_Y: start_vy_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            speed_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                OP_ACCEPT: sat_reg <= 1'b0;
                OP_LOAD: begin
                    pos_x_reg <= start_x_reg;
                    pos_y_reg <= start_y_reg;
                    vel_x_reg <= start_vx_reg;
                    vel_y_reg <= start_vy_reg;
                end
                OP_KS: if (prod_sh[65:31] != '0) sat_reg <= 1'b1;
                OP_FX: if (c_fx[32]) sat_reg <= 1'b1;
                OP_FY: if (c_fy[32]) sat_reg <= 1'b1;
                OP_DIV_END: if (c_ax[32] || c_ay[32]) sat_reg <= 1'b1;
                OP_VX: begin
                    vel_x_reg <= c_vx[31:0];
                    if (c_vx[32]) sat_reg <= 1'b1;
                end
                OP_VY: begin
                    vel_y_reg <= c_vy[31:0];
                    if (c_vy[32]) sat_reg <= 1'b1;
                end
                OP_PX: begin
                    pos_x_reg <= c_px[31:0];
                    if (c_px[32]) sat_reg <= 1'b1;
                end
                OP_PY: begin
                    pos_y_reg <= c_py[31:0];
                    if (c_py[32]) sat_reg <= 1'b1;
                end
                OP_SQRT_END: begin
                    if (root[31]) begin
                        speed_reg <= MAX31;
                        sat_reg   <= 1'b1;
                    end else begin
                        speed_reg <= root[30:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and scratch registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_ACCEPT: begin
                restart_reg <= in_flags[0];
                coll_reg    <= in_flags[1];
                dt_reg      <= in_data[16:0];
                imp_x_reg   <= in_data[48:17];
                imp_y_reg   <= in_data[80:49];
            end
            OP_KS:     ks_reg <= (prod_sh[65:31] != '0) ? MAX31 : prod_sh[30:0];
            OP_FX:     fx_reg <= c_fx[31:0];
            OP_FY:     fy_reg <= c_fy[31:0];
            OP_IMPACT: begin
                fx_reg <= imp_x_reg;
                fy_reg <= imp_y_reg;
            end
            OP_DIV_END: begin
                ax_reg <= c_ax[31:0];
                ay_reg <= c_ay[31:0];
            end
            OP_SQ_Y:   acc_reg <= 64'(prod_reg);
            OP_SQ_SUM: acc_reg <= sq_sum;
            default: ;
        endcase
    end

    pfe_div #(.NUM_W(NUM_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.op == OP_DIV_START),
        .numer(numer_x), .denom(denom), .done(div_x_done), .quot(quot_x)
    );

    pfe_div #(.NUM_W(NUM_W)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.op == OP_DIV_START),
        .numer(numer_y), .denom(denom), .done(div_y_done), .quot(quot_y)
    );

    pfe_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.op == OP_SQRT_START),
        .radicand(acc_reg), .done(sqrt_done), .root(root)
    );

    assign status.restart   = restart_reg;
    assign status.collision = coll_reg;
    assign status.div_done  = div_x_done & div_y_done;
    assign status.sqrt_done = sqrt_done;

    assign out_data = {1'b0, speed_reg, vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
    assign out_sat  = sat_reg;
endmodule

/* rtl/pfe_ctrl.sv */
// Controller: sequences one step through the datapath and runs the handshakes.
module pfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pfe_pkg::dp_status_t status,
    output pfe_pkg::dp_cmd_t    cmd
);
    import pfe_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.restart) begin
                    state_next = S_LOAD;
                end else if (status.collision) begin
                    state_next = S_IMPACT;
                end else begin
                    state_next = S_MUL_KS;
                end
            end
            S_LOAD:    begin cmd.op = OP_LOAD;    state_next = S_SQ_X;      end
            S_MUL_KS:  begin cmd.op = OP_MUL_KS;  state_next = S_KS;        end
            S_KS:      begin cmd.op = OP_KS;      state_next = S_MUL_DX;    end
            S_MUL_DX:  begin cmd.op = OP_MUL_DX;  state_next = S_FX;        end
            S_FX:      begin cmd.op = OP_FX;      state_next = S_MUL_DY;    end
            S_MUL_DY:  begin cmd.op = OP_MUL_DY;  state_next = S_FY;        end
            S_FY:      begin cmd.op = OP_FY;      state_next = S_DIV_START; end
            S_IMPACT:  begin cmd.op = OP_IMPACT;  state_next = S_DIV_START; end
            S_DIV_START: begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN: if (status.div_done) state_next = S_DIV_END;
            S_DIV_END: begin cmd.op = OP_DIV_END; state_next = S_MUL_AX;    end
            S_MUL_AX:  begin cmd.op = OP_MUL_AX;  state_next = S_VX;        end
            S_VX:      begin cmd.op = OP_VX;      state_next = S_MUL_AY;    end
            S_MUL_AY:  begin cmd.op = OP_MUL_AY;  state_next = S_VY;        end
            S_VY:      begin cmd.op = OP_VY;      state_next = S_MUL_PX;    end
            S_MUL_PX:  begin cmd.op = OP_MUL_PX;  state_next = S_PX;        end
            S_PX:      begin cmd.op = OP_PX;      state_next = S_MUL_PY;    end
            S_MUL_PY:  begin cmd.op = OP_MUL_PY;  state_next = S_PY;        end
            S_PY:      begin cmd.op = OP_PY;      state_next = S_SQ_X;      end
            S_SQ_X:    begin cmd.op = OP_SQ_X;    state_next = S_SQ_Y;      end
            S_SQ_Y:    begin cmd.op = OP_SQ_Y;    state_next = S_SQ_SUM;    end
            S_SQ_SUM:  begin cmd.op = OP_SQ_SUM;  state_next = S_SQRT_START; end
            S_SQRT_START: begin
                cmd.op     = OP_SQRT_START;
                state_next = S_SQRT_RUN;
            end
            S_SQRT_RUN: if (status.sqrt_done) state_next = S_SQRT_END;
            S_SQRT_END: begin cmd.op = OP_SQRT_END; state_next = S_OUT;     end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* test/tb_particle_force_euler_step.sv */
// Testbench for particle_force_euler_step: directed table plus random steps, self-checking.
module tb_particle_force_euler_step;
    timeunit 1ns;
    timeprecision 1ps;
    import pfe_pkg::*;

    localparam int FB = 16;                 // fraction bits, matches dut default
    localparam longint MAXS = 64'sd2147483647;
    localparam longint MINS = -64'sd2147483648;
    localparam int NO_ACCEPT_LIMIT = 4000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES = 400;       // long receiver hold-off

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [87:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid, m_tready;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    particle_force_euler_step dut (.*);

    // one step result
    typedef struct packed {
        logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
        logic [30:0]        speed;
        logic               sat;
    } step_res_t;

    // directed table row: either a register write or a step request
    typedef struct {
        bit         is_cfg;
        cfg_reg_t   reg_idx;
        logic [31:0] value;
        bit         restart, coll;
        logic [16:0] dt;
        logic [31:0] fx, fy;
        bit         has_exp;
        step_res_t  exp_res;
    } dir_row_t;

    step_res_t pending_q[$];
    dir_row_t  dir_tab[$];
    int        fail_cnt = 0;
    int        idle_cnt = 0;
    bit        no_idle = 0;
    bit        hold_req = 0;

    // integrator shadow: config and state
    logic [30:0] k_mass, k_drag;
    longint      k_grav, k_wind, k_sx, k_sy, k_svx, k_svy;
    longint      st_px, st_py, st_vx, st_vy;
    longint      st_speed;

    function automatic longint clamp32(longint x, inout bit s);
        if (x > MAXS) begin s = 1; return MAXS; end
        if (x < MINS) begin s = 1; return MINS; end
        return x;
    endfunction

    // 32-iteration integer square root, clamped to 31 bits
    function automatic longint speed_of(longint vx, longint vy, inout bit s);
        longint unsigned ax, ay, n, r, trial;
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        n = ax * ax + ay * ay;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= n) r = trial;
        end
        if (r > 64'h7FFF_FFFF) begin s = 1; r = 64'h7FFF_FFFF; end
        return longint'(r);
    endfunction

    function automatic void cfg_shadow(cfg_reg_t r, logic [31:0] v);
        case (r)
            REG_MASS:        k_mass = v[30:0];
            REG_GRAVITY:     k_grav = longint'(signed'(v));
            REG_DRAG:        k_drag = v[30:0];
            REG_WIND:        k_wind = longint'(signed'(v));
            REG_START_X:     k_sx   = longint'(signed'(v));
            REG_START_Y:     k_sy   = longint'(signed'(v));
            REG_START_VEL_X: k_svx  = longint'(signed'(v));
            REG_START_VEL_Y: k_svy  = longint'(signed'(v));
            default: ;
        endcase
    endfunction

    // advance the shadow state by one request and return the new state
    function automatic step_res_t euler_step(bit restart, logic [16:0] dt_in, bit coll,
                                             logic [31:0] ifx, logic [31:0] ify);
        bit s;
        longint fx, fy, ks, m, ax, ay, dt;
        step_res_t r;
        s = 0;
        dt = longint'(dt_in);
        if (restart) begin
            st_px = k_sx; st_py = k_sy; st_vx = k_svx; st_vy = k_svy;
        end else begin
            if (coll) begin
                fx = longint'(signed'(ifx));
                fy = longint'(signed'(ify));
            end else begin
                // drag uses the speed kept from the previous step
                ks = (longint'(k_drag) * st_speed) >>> FB;
                if (ks > MAXS) begin s = 1; ks = MAXS; end
                fx = k_wind - ((ks * st_vx) >>> FB);
                fy = k_grav - ((ks * st_vy) >>> FB);
            end
            fx = clamp32(fx, s);
            fy = clamp32(fy, s);
            m  = (k_mass == 0) ? 1 : longint'(k_mass);
            ax = clamp32((fx <<< FB) / m, s);
            ay = clamp32((fy <<< FB) / m, s);
            st_vx = clamp32(st_vx + ((ax * dt) >>> FB), s);
            st_vy = clamp32(st_vy + ((ay * dt) >>> FB), s);
            st_px = clamp32(st_px + ((st_vx * dt) >>> FB), s);
            st_py = clamp32(st_py + ((st_vy * dt) >>> FB), s);
        end
        st_speed = speed_of(st_vx, st_vy, s);
        r.pos_x = st_px[31:0]; r.pos_y = st_py[31:0];
        r.vel_x = st_vx[31:0]; r.vel_y = st_vy[31:0];
        r.speed = st_speed[30:0];
        r.sat   = s;
        return r;
    endfunction

    // clock
    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- sender side ----------------

    // offer one request; returns at the edge where it was taken
    task automatic send_req(bit restart, logic [16:0] dt, bit coll,
                            logic [31:0] fx, logic [31:0] fy, bit has_exp, step_res_t exp_res);
        step_res_t pred;
        if (!no_idle && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, fy, fx, dt};
        s_tuser  <= {coll, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = euler_step(restart, dt, coll, fx, fy);
        // typed rows carry their own answer; the shadow still advances
        pending_q.push_back(has_exp ? exp_res : pred);
    endtask

    // drop valid and wait until the block has drained and gone idle
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    task automatic reg_write(cfg_reg_t r, logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        cfg_shadow(r, v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void add_req(bit restart, logic [16:0] dt, bit coll,
                                    logic [31:0] fx, logic [31:0] fy);
        dir_row_t d;
        d = '{reg_idx: REG_MASS, default: '0};
        d.restart = restart; d.dt = dt; d.coll = coll; d.fx = fx; d.fy = fy;
        dir_tab.push_back(d);
    endfunction

    function automatic void add_typed(bit restart, logic [16:0] dt, bit coll,
                                      step_res_t e);
        dir_row_t d;
        d = '{reg_idx: REG_MASS, default: '0};
        d.restart = restart; d.dt = dt; d.coll = coll;
        d.has_exp = 1; d.exp_res = e;
        dir_tab.push_back(d);
    endfunction

    function automatic void add_cfg(cfg_reg_t r, logic [31:0] v);
        dir_row_t d;
        d = '{reg_idx: REG_MASS, default: '0};
        d.is_cfg = 1; d.reg_idx = r; d.value = v;
        dir_tab.push_back(d);
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 20) << 16;
            3: return -($urandom_range(0, 20) << 16);
            default: return $urandom;
        endcase
    endfunction

    // new settings for a random phase; p selects a flavor
    task automatic phase_cfg(int p);
        logic [31:0] mv, dv;
        case (p)
            0: begin mv = 32'd0;          dv = 32'h7FFF_FFFF; end   // zero mass, max drag
            1: begin mv = 32'h7FFF_FFFF;  dv = 32'd0;         end   // heaviest
            2: begin mv = 32'd1;          dv = $urandom_range(1, 4096); end
            default: begin
                mv = $urandom_range(1 << 12, 1 << 20);
                dv = $urandom_range(0, 1 << 14);
            end
        endcase
        reg_write(REG_MASS, mv);
        reg_write(REG_GRAVITY, (p == 3) ? 32'hFFF6_3EA4 : pick32());
        reg_write(REG_DRAG, dv);
        reg_write(REG_WIND, pick32());
        reg_write(REG_START_X, pick32());
        reg_write(REG_START_Y, pick32());
        reg_write(REG_START_VEL_X, pick32());
        reg_write(REG_START_VEL_Y, pick32());
    endtask

    task automatic random_req();
        logic [16:0] dt;
        logic [31:0] fx, fy;
        bit big;
        big = ($urandom_range(99) < 20);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: dt = 17'($urandom_range(0, 4096));
            5, 6, 7:       dt = 17'($urandom_range(0, 65536));
            default:       dt = 17'($urandom);            // full 17 bits, above 1.0 too
        endcase
        fx = big ? $urandom : (32'($urandom_range(0, 1 << 21)) - (1 << 20));
        fy = big ? $urandom : (32'($urandom_range(0, 1 << 21)) - (1 << 20));
        send_req($urandom_range(99) < 8, dt, $urandom_range(99) < 35, fx, fy, 0, '0);
    endtask

    initial begin
        step_res_t e;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        // shadow reset values
        k_mass = 31'(1 << FB); k_grav = -642908; k_drag = 0; k_wind = 0;
        k_sx = 0; k_sy = 0; k_svx = 0; k_svy = 0;
        st_px = 0; st_py = 0; st_vx = 0; st_vy = 0; st_speed = 0;

        // directed table
        e = '0;
        add_typed(1, 17'd0, 0, e);                          // restart at reset: all zero
        add_typed(0, 17'd0, 1, e);                          // zero step leaves rest intact
        e.pos_x = 0; e.vel_x = 0;
        e.pos_y = -32'sd642908; e.vel_y = -32'sd642908; e.speed = 31'd642908;
        add_typed(0, 17'd65536, 0, e);                      // one second of default gravity
        add_req(0, 17'h1FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000); // large step, impact extremes
        add_req(0, 17'd1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req(0, 17'h1FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cfg(REG_START_X, 32'h8000_0000);
        add_cfg(REG_START_Y, 32'h8000_0000);
        add_cfg(REG_START_VEL_X, 32'h8000_0000);
        add_cfg(REG_START_VEL_Y, 32'h8000_0000);
        e.pos_x = 32'sh8000_0000; e.pos_y = 32'sh8000_0000;
        e.vel_x = 32'sh8000_0000; e.vel_y = 32'sh8000_0000;
        e.speed = MAX31; e.sat = 1;
        add_typed(1, 17'd0, 0, e);                          // restart, speed clamps
        add_cfg(REG_MASS, 32'd0);                           // zero mass acts as one LSB
        add_cfg(REG_DRAG, 32'h7FFF_FFFF);
        add_req(0, 17'd1, 0, 32'd0, 32'd0);
        add_req(0, 17'd65536, 0, 32'd0, 32'd0);
        add_cfg(REG_MASS, 32'h7FFF_FFFF);
        add_cfg(REG_GRAVITY, 32'h7FFF_FFFF);
        add_cfg(REG_WIND, 32'h8000_0000);
        add_cfg(REG_START_X, 32'h7FFF_FFFF);
        add_cfg(REG_START_Y, 32'h7FFF_FFFF);
        add_cfg(REG_START_VEL_X, 32'h7FFF_FFFF);
        add_cfg(REG_START_VEL_Y, 32'h7FFF_FFFF);
        e.pos_x = 32'sh7FFF_FFFF; e.pos_y = 32'sh7FFF_FFFF;
        e.vel_x = 32'sh7FFF_FFFF; e.vel_y = 32'sh7FFF_FFFF;
        e.speed = MAX31; e.sat = 1;
        add_typed(1, 17'd0, 0, e);
        add_req(0, 17'd65536, 0, 32'd0, 32'd0);
        add_req(0, 17'h1FFFF, 0, 32'd0, 32'd0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain();
                reg_write(dir_tab[i].reg_idx, dir_tab[i].value);
            end else begin
                send_req(dir_tab[i].restart, dir_tab[i].dt, dir_tab[i].coll,
                         dir_tab[i].fx, dir_tab[i].fy, dir_tab[i].has_exp, dir_tab[i].exp_res);
            end
        end

        // random phases, about 450 requests in all
        for (int p = 0; p < 6; p++) begin
            drain();
            phase_cfg(p);
            no_idle = (p == 4);                             // back-to-back stretch
            send_req(1, 17'd0, 0, 32'd0, 32'd0, 0, '0);     // start from the loaded state
            for (int n = 0; n < 75; n++) begin
                if (p == 2 && n == 10) hold_req = 1;        // receiver stalls, sender keeps offering
                if (p == 3 && n == 30) begin
                    s_tvalid <= 1'b0;                       // sender waits out every result
                    wait (pending_q.size() == 0);
                    @(posedge aclk);
                end
                random_req();
            end
            no_idle = 0;
        end

        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (150) @(posedge aclk);
        if (fail_cnt == 0) $display("particle_force_euler_step verification clean");
        else $display("particle_force_euler_step verification failed");
        $finish;
    end

    // ---------------- receiver side ----------------
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 27);
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge aclk) begin
        step_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x = m_tdata[31:0];   got.pos_y = m_tdata[63:32];
            got.vel_x = m_tdata[95:64];  got.vel_y = m_tdata[127:96];
            got.speed = m_tdata[158:128];
            got.sat   = m_tuser[0];
            if (pending_q.size() == 0) begin
                $error("unexpected result: nothing pending");
                fail_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x); fail_cnt++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y); fail_cnt++;
                end
                if (got.vel_x !== want.vel_x) begin
                    $error("vel_x exp %0d got %0d", want.vel_x, got.vel_x); fail_cnt++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $error("vel_y exp %0d got %0d", want.vel_y, got.vel_y); fail_cnt++;
                end
                if (got.speed !== want.speed) begin
                    $error("speed_out exp %0d got %0d", want.speed, got.speed); fail_cnt++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated exp %0d got %0d", want.sat, got.sat); fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= NO_ACCEPT_LIMIT) begin
            $display("particle_force_euler_step verification failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

endmodule
